>>> hdl/obpf_pkg.sv
`timescale 1ns / 1ps
package obpf_pkg;

  localparam int INDEX_BITS_DEFAULT = 24;

  // Field widths
  localparam int COORD_W = 32;   // Q16.16 point and center coordinates
  localparam int ROT_W   = 16;   // Q2.14 rotation entries
  localparam int ROT_FRAC = 14;
  localparam int HALF_W  = 30;   // Q14.16 half lengths, unsigned

  // Internal widths; offsets and half axes Q.30, products Q.44
  localparam int DIFF_W  = COORD_W + 1;            // point minus center
  localparam int REL_W   = DIFF_W + ROT_FRAC;      // relative point
  localparam int AXIS_W  = ROT_W + HALF_W + 1;     // rotated half axis
  localparam int W_W     = REL_W + 1;              // point minus corner
  localparam int PROD_W  = ROT_W + W_W;            // one cross product term
  localparam int CROSS_W = PROD_W + 1;             // cross product

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_XX   = 3'd0,
    REG_ROT_XY   = 3'd1,
    REG_ROT_YX   = 3'd2,
    REG_ROT_YY   = 3'd3,
    REG_CENTER_X = 3'd4,
    REG_CENTER_Y = 3'd5,
    REG_HALF_X   = 3'd6,
    REG_HALF_Y   = 3'd7
  } cfg_reg_t;

  localparam logic signed [ROT_W-1:0] ROT_ONE = 16'sd16384;

  // Sign of one edge cross product
  typedef struct packed {
    logic pos;
    logic neg;
  } edge_sign_t;

endpackage

>>> hdl/oriented_box_point_filter.sv
`timescale 1ns / 1ps
// Oriented box point filter. Streams indexed 2D points and flags each one
// that lies strictly inside a rotated, padded rectangle: center (center_x,
// center_y) in Q16.16, half lengths half_length_x/y in Q14.16, and the xy
// part of the rotation in Q2.14 (rot_xx, rot_xy, rot_yx, rot_yy, row by
// column). Points on the boundary, and every point of a rectangle with a
// zero half length, are reported outside. The test is exact, with no
// rounding or saturation, for every register and coordinate value. One
// point is accepted per clock cycle while the output is not stalled; a
// result passes through the five register stages of the pipeline (capture,
// center subtract, corner offsets, cross-product multiply, sign test and
// output register), the first of which loads on the accepting edge itself.
// Each stage holds its beat when the one after it is full, so stalls on the
// output side fill bubbles before they reach the input. Write configuration
// only while no point is in flight; a write takes effect for points
// accepted from the next cycle.
// Registers, by index: 0 rot_xx, 1 rot_xy, 2 rot_yx, 3 rot_yy, 4 center_x,
// 5 center_y, 6 half_length_x, 7 half_length_y; written data is truncated
// to the register width. Reset: identity rotation, all else zero.
module oriented_box_point_filter
  import obpf_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,

  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,

  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [INDEX_BITS-1:0]   point_index,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic                    final_point,

  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [INDEX_BITS-1:0]   result_index,
  output logic                    is_inside,
  output logic                    final_result
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic signed [ROT_W-1:0]   rot_xx, rot_xy, rot_yx, rot_yy;
  logic signed [COORD_W-1:0] center_x, center_y;
  logic [HALF_W-1:0]         half_x, half_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_xx   <= ROT_ONE;
      rot_xy   <= '0;
      rot_yx   <= '0;
      rot_yy   <= ROT_ONE;
      center_x <= '0;
      center_y <= '0;
      half_x   <= '0;
      half_y   <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROT_XX:   rot_xx   <= cfg_data[ROT_W-1:0];
        REG_ROT_XY:   rot_xy   <= cfg_data[ROT_W-1:0];
        REG_ROT_YX:   rot_yx   <= cfg_data[ROT_W-1:0];
        REG_ROT_YY:   rot_yy   <= cfg_data[ROT_W-1:0];
        REG_CENTER_X: center_x <= cfg_data[COORD_W-1:0];
        REG_CENTER_Y: center_y <= cfg_data[COORD_W-1:0];
        REG_HALF_X:   half_x   <= cfg_data[HALF_W-1:0];
        REG_HALF_Y:   half_y   <= cfg_data[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  // Rotated half axes R*(hx,0) and R*(0,hy), Q.30. These are registered
  // from the configuration registers, which is early enough: a point first
  // needs them when it enters the corner offset stage.
  logic signed [AXIS_W-1:0] ux, uy, vx, vy;

  always_ff @(posedge clk) begin
    ux <= AXIS_W'(rot_xx) * AXIS_W'($signed({1'b0, half_x}));
    uy <= AXIS_W'(rot_yx) * AXIS_W'($signed({1'b0, half_x}));
    vx <= AXIS_W'(rot_xy) * AXIS_W'($signed({1'b0, half_y}));
    vy <= AXIS_W'(rot_yy) * AXIS_W'($signed({1'b0, half_y}));
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or the stage
  // after it loads in the same cycle.
  // ---------------------------------------------------------------------
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic load1, load2, load3, load4, load5;

  assign load5    = !s5_valid || out_ready;
  assign load4    = !s4_valid || load5;
  assign load3    = !s3_valid || load4;
  assign load2    = !s2_valid || load3;
  assign load1    = !s1_valid || load2;
  assign in_ready = load1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      if (load1) s1_valid <= in_valid;
      if (load2) s2_valid <= s1_valid;
      if (load3) s3_valid <= s2_valid;
      if (load4) s4_valid <= s3_valid;
      if (load5) s5_valid <= s4_valid;
    end
  end

  // Sideband that rides along with each beat
  logic [INDEX_BITS-1:0] s1_index, s2_index, s3_index, s4_index, s5_index;
  logic                  s1_final, s2_final, s3_final, s4_final, s5_final;

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_index <= point_index;
      s1_final <= final_point;
    end
    if (load2) begin
      s2_index <= s1_index;
      s2_final <= s1_final;
    end
    if (load3) begin
      s3_index <= s2_index;
      s3_final <= s2_final;
    end
    if (load4) begin
      s4_index <= s3_index;
      s4_final <= s3_final;
    end
    if (load5) begin
      s5_index <= s4_index;
      s5_final <= s4_final;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: capture the point
  // ---------------------------------------------------------------------
  logic signed [COORD_W-1:0] s1_px, s1_py;

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_px <= point_x;
      s1_py <= point_y;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: point relative to the center, scaled to Q.30
  // ---------------------------------------------------------------------
  logic signed [DIFF_W-1:0] diff_x, diff_y;
  logic signed [REL_W-1:0]  s2_dx, s2_dy;

  assign diff_x = DIFF_W'(s1_px) - DIFF_W'(center_x);
  assign diff_y = DIFF_W'(s1_py) - DIFF_W'(center_y);

  always_ff @(posedge clk) begin
    if (load2) begin
      s2_dx <= {diff_x, {ROT_FRAC{1'b0}}};
      s2_dy <= {diff_y, {ROT_FRAC{1'b0}}};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: point minus each corner, corners a, b, c, d counterclockwise
  // ---------------------------------------------------------------------
  logic signed [W_W-1:0] dx_w, dy_w, ux_w, uy_w, vx_w, vy_w;
  logic signed [W_W-1:0] s3_wax, s3_way, s3_wbx, s3_wby;
  logic signed [W_W-1:0] s3_wcx, s3_wcy, s3_wdx, s3_wdy;

  assign dx_w = W_W'(s2_dx);
  assign dy_w = W_W'(s2_dy);
  assign ux_w = W_W'(ux);
  assign uy_w = W_W'(uy);
  assign vx_w = W_W'(vx);
  assign vy_w = W_W'(vy);

  always_ff @(posedge clk) begin
    if (load3) begin
      s3_wax <= dx_w - ux_w - vx_w;
      s3_way <= dy_w - uy_w - vy_w;
      s3_wbx <= dx_w + ux_w - vx_w;
      s3_wby <= dy_w + uy_w - vy_w;
      s3_wcx <= dx_w + ux_w + vx_w;
      s3_wcy <= dy_w + uy_w + vy_w;
      s3_wdx <= dx_w - ux_w + vx_w;
      s3_wdy <= dy_w - uy_w + vy_w;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: cross-product terms against the rotation columns. Each edge
  // direction is a column of R scaled by a half length, so its sign alone
  // decides the test once the scale factor is pulled out.
  // ---------------------------------------------------------------------
  edge_sign_t sign_a, sign_b, sign_c, sign_d;

  obpf_edge_cross u_edge_a (
    .clk   (clk),
    .load  (load4),
    .col_x (rot_xx),
    .col_y (rot_yx),
    .w_x   (s3_wax),
    .w_y   (s3_way),
    .sign  (sign_a)
  );

  obpf_edge_cross u_edge_b (
    .clk   (clk),
    .load  (load4),
    .col_x (rot_xy),
    .col_y (rot_yy),
    .w_x   (s3_wbx),
    .w_y   (s3_wby),
    .sign  (sign_b)
  );

  obpf_edge_cross u_edge_c (
    .clk   (clk),
    .load  (load4),
    .col_x (rot_xx),
    .col_y (rot_yx),
    .w_x   (s3_wcx),
    .w_y   (s3_wcy),
    .sign  (sign_c)
  );

  obpf_edge_cross u_edge_d (
    .clk   (clk),
    .load  (load4),
    .col_x (rot_xy),
    .col_y (rot_yy),
    .w_x   (s3_wdx),
    .w_y   (s3_wdy),
    .sign  (sign_d)
  );

  // ---------------------------------------------------------------------
  // Stage 5: sign test and output register. Edges a and b use the negated
  // column direction, so their cross product must be negative.
  // ---------------------------------------------------------------------
  logic inside_next;
  logic s5_inside;

  assign inside_next = (half_x != '0) && (half_y != '0) &&
                       sign_a.neg && sign_b.neg && sign_c.pos && sign_d.pos;

  always_ff @(posedge clk) begin
    if (load5) begin
      s5_inside <= inside_next;
    end
  end

  assign out_valid    = s5_valid;
  assign result_index = s5_index;
  assign is_inside    = s5_inside;
  assign final_result = s5_final;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> s1_valid)
    else $error("accepted beat did not enter the first stage");

  a_empty_s1_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input stalled with an empty first stage");

  a_s4_drains: assert property (@(posedge clk) disable iff (rst)
    (s4_valid && load5) |=> s5_valid)
    else $error("beat lost between multiply and output stage");

  a_s3_holds: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && !load4) |=> (s3_valid && $stable(s3_wax) && $stable(s3_index)))
    else $error("stalled corner stage did not hold its beat");

endmodule

>>> hdl/obpf_edge_cross.sv
`timescale 1ns / 1ps
module obpf_edge_cross
  import obpf_pkg::*;
(
  input  logic                     clk,
  input  logic                     load,
  input  logic signed [ROT_W-1:0]  col_x,
  input  logic signed [ROT_W-1:0]  col_y,
  input  logic signed [W_W-1:0]    w_x,
  input  logic signed [W_W-1:0]    w_y,
  output edge_sign_t               sign
);

  logic signed [PROD_W-1:0]  prod_a;
  logic signed [PROD_W-1:0]  prod_b;
  logic signed [CROSS_W-1:0] cross_val;

  // Register both terms, then subtract in the following stage
  always_ff @(posedge clk) begin
    if (load) begin
      prod_a <= PROD_W'(col_x) * PROD_W'(w_y);
      prod_b <= PROD_W'(col_y) * PROD_W'(w_x);
    end
  end

  assign cross_val = CROSS_W'(prod_a) - CROSS_W'(prod_b);
  assign sign.neg  = cross_val[CROSS_W-1];
  assign sign.pos  = !cross_val[CROSS_W-1] && (cross_val != '0);

endmodule
